/* src/csc_pkg.sv */
package csc_pkg;

  localparam int unsigned WEIGHT_BITS = 32;
  localparam int unsigned SUM_BITS    = 48;
  localparam int unsigned TOT_BITS    = SUM_BITS + 1;
  localparam int unsigned SQ_BITS     = 2 * SUM_BITS;
  localparam int unsigned PROD_BITS   = SQ_BITS + TOT_BITS;
  localparam int unsigned DIGIT       = 8;
  localparam int unsigned DIG_N       = (TOT_BITS + DIGIT - 1) / DIGIT;
  localparam int unsigned DIG_CNT_W   = $clog2(DIG_N + 1);

  // figure = floor(sqrt(s*s*2^FIG_SHIFT / t)), quotient limited to QBITS
  localparam int unsigned FIG_SHIFT   = 24;
  localparam int unsigned QBITS       = 64;
  localparam int unsigned SAT_SHIFT   = QBITS - FIG_SHIFT;
  localparam int unsigned ROOT_BITS   = QBITS / 2;
  localparam int unsigned RT_BITS     = ROOT_BITS + 4;
  localparam int unsigned FIG_CNT_W   = $clog2(QBITS + 1);

  localparam logic signed [31:0] NONE_EDGE = -32'sd65536;

  typedef struct packed {
    logic [31:0]        signal_weight;
    logic [31:0]        background_weight;
    logic signed [31:0] bin_low_edge;
    logic               last_bin;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] best_edge;
    logic [31:0]        best_figure;
    logic               cut_found;
  } out_item_t;

  typedef struct packed {
    logic                start;
    logic [SQ_BITS-1:0]  a;
    logic [TOT_BITS-1:0] b;
  } mul_cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_EVAL, BK_SQ, BK_PROD, BK_LAST, BK_FSQ, BK_FIG, BK_EMIT
  } back_state_e;

  typedef enum logic [1:0] {
    FG_IDLE, FG_DIV, FG_ROOT, FG_DONE
  } fig_state_e;

endpackage

/* src/csc_front.sv */
module csc_front import csc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     q_valid_o,
  input  logic     q_pop_i,
  output in_item_t q_item_o
);

  in_item_t   mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;
  in_item_t   clean;

  // weights carry only their low WEIGHT_BITS bits
  always_comb begin
    clean = in_item_i;
    clean.signal_weight = 32'(in_item_i.signal_weight[WEIGHT_BITS-1:0]);
    clean.background_weight = 32'(in_item_i.background_weight[WEIGHT_BITS-1:0]);
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= clean;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

/* src/csc_mul.sv */
module csc_mul import csc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mul_cmd_t             cmd_i,
  output logic                 done_o,
  output logic [PROD_BITS-1:0] p_o
);

  localparam int unsigned PP_BITS = SQ_BITS + DIGIT;

  logic [SQ_BITS-1:0]       a_q;
  logic [DIG_N*DIGIT-1:0]   b_q;
  logic [PROD_BITS-1:0]     acc_q;
  logic [DIG_CNT_W-1:0]     cnt_q;
  logic                     busy_q;
  logic [PP_BITS-1:0]       pp;

  // msb digit first: acc = acc * 2^DIGIT + a * digit
  assign pp     = PP_BITS'(a_q) * PP_BITS'(b_q[DIG_N*DIGIT-1 -: DIGIT]);
  assign done_o = busy_q && (cnt_q == '0);
  assign p_o    = acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      a_q   <= cmd_i.a;
      b_q   <= (DIG_N*DIGIT)'(cmd_i.b);
      acc_q <= '0;
    end else if (busy_q && cnt_q != '0) begin
      b_q   <= b_q << DIGIT;
      acc_q <= (acc_q << DIGIT) + PROD_BITS'(pp);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= DIG_CNT_W'(DIG_N);
    end else if (busy_q) begin
      if (cnt_q == '0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

/* src/csc_figure.sv */
module csc_figure import csc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SQ_BITS-1:0]  sq_i,
  input  logic [TOT_BITS-1:0] t_i,
  output logic                done_o,
  output logic [31:0]         fig_o
);

  fig_state_e            state_q, state_d;
  logic [TOT_BITS-1:0]   rem_q;
  logic [TOT_BITS-1:0]   t_q;
  logic [QBITS-1:0]      n_q;
  logic [QBITS-1:0]      quo_q;
  logic [RT_BITS-1:0]    r_q;
  logic [ROOT_BITS-1:0]  root_q;
  logic [FIG_CNT_W-1:0]  cnt_q;
  logic [31:0]           fig_q;
  logic [TOT_BITS:0]     rem2;
  logic                  qbit;
  logic [RT_BITS-1:0]    r2, trial;
  logic                  rbit;
  logic                  sat;

  assign sat    = sq_i >= (SQ_BITS'(t_i) << SAT_SHIFT);
  assign rem2   = {rem_q, n_q[QBITS-1]};
  assign qbit   = rem2 >= {1'b0, t_q};
  assign r2     = {r_q[RT_BITS-3:0], quo_q[QBITS-1 -: 2]};
  assign trial  = RT_BITS'({root_q, 2'b01});
  assign rbit   = r2 >= trial;
  assign done_o = (state_q == FG_DONE);
  assign fig_o  = fig_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FG_IDLE: if (start_i) state_d = sat ? FG_DONE : FG_DIV;
      FG_DIV:  if (cnt_q == FIG_CNT_W'(1)) state_d = FG_ROOT;
      FG_ROOT: if (cnt_q == FIG_CNT_W'(1)) state_d = FG_DONE;
      FG_DONE: state_d = FG_IDLE;
      default: state_d = FG_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      FG_IDLE: begin
        // high part of the numerator is below t when not saturated
        rem_q  <= TOT_BITS'(sq_i[SQ_BITS-1:SAT_SHIFT]);
        n_q    <= {sq_i[SAT_SHIFT-1:0], FIG_SHIFT'(0)};
        t_q    <= t_i;
        quo_q  <= '0;
        fig_q  <= '1;
        cnt_q  <= FIG_CNT_W'(QBITS);
      end
      FG_DIV: begin
        rem_q <= qbit ? TOT_BITS'(rem2 - {1'b0, t_q}) : rem_q[TOT_BITS-1:0] << 1
                 | TOT_BITS'(n_q[QBITS-1]);
        n_q   <= n_q << 1;
        quo_q <= {quo_q[QBITS-2:0], qbit};
        cnt_q <= (cnt_q == FIG_CNT_W'(1)) ? FIG_CNT_W'(ROOT_BITS) : cnt_q - 1'b1;
        r_q    <= '0;
        root_q <= '0;
      end
      FG_ROOT: begin
        r_q    <= rbit ? r2 - trial : r2;
        root_q <= {root_q[ROOT_BITS-2:0], rbit};
        quo_q  <= quo_q << 2;
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == FIG_CNT_W'(1)) fig_q <= 32'({root_q[ROOT_BITS-2:0], rbit});
      end
      FG_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FG_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/csc_back.sv */
module csc_back import csc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  output logic      q_pop_o,
  input  in_item_t  q_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  back_state_e          state_q, state_d;
  logic [SUM_BITS-1:0]  sig_q, sig_d, bkg_q, bkg_d;
  logic [SUM_BITS-1:0]  best_s_q, best_s_d;
  logic [TOT_BITS-1:0]  best_t_q, best_t_d;
  logic signed [31:0]   best_pos_q, best_pos_d;
  logic                 found_q, found_d;
  logic signed [31:0]   edge_q;
  logic                 last_q;
  logic [TOT_BITS-1:0]  tot;
  logic [SUM_BITS:0]    sig_add, bkg_add;
  mul_cmd_t             cmd0, cmd1;
  logic                 done0, done1;
  logic [PROD_BITS-1:0] p0, p1;
  logic                 fig_start, fig_done;
  logic [31:0]          fig;
  logic [31:0]          fig_q;
  logic                 out_valid_q, out_load;
  out_item_t            out_q;

  assign tot     = TOT_BITS'(sig_q) + TOT_BITS'(bkg_q);
  assign sig_add = {1'b0, sig_q} + (SUM_BITS+1)'(q_item_i.signal_weight);
  assign bkg_add = {1'b0, bkg_q} + (SUM_BITS+1)'(q_item_i.background_weight);

  csc_mul u_mul0 (.clk_i, .rst_ni, .cmd_i(cmd0), .done_o(done0), .p_o(p0));
  csc_mul u_mul1 (.clk_i, .rst_ni, .cmd_i(cmd1), .done_o(done1), .p_o(p1));

  csc_figure u_fig (
    .clk_i, .rst_ni,
    .start_i(fig_start),
    .sq_i   (p0[SQ_BITS-1:0]),
    .t_i    (best_t_q),
    .done_o (fig_done),
    .fig_o  (fig)
  );

  always_comb begin
    state_d    = state_q;
    sig_d      = sig_q;
    bkg_d      = bkg_q;
    best_s_d   = best_s_q;
    best_t_d   = best_t_q;
    best_pos_d = best_pos_q;
    found_d    = found_q;
    q_pop_o    = 1'b0;
    fig_start  = 1'b0;
    out_load   = 1'b0;
    cmd0       = '{start: 1'b0, a: SQ_BITS'(sig_q), b: TOT_BITS'(sig_q)};
    cmd1       = '{start: 1'b0, a: SQ_BITS'(best_s_q), b: TOT_BITS'(best_s_q)};
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          sig_d   = sig_add[SUM_BITS] ? '1 : sig_add[SUM_BITS-1:0];
          bkg_d   = bkg_add[SUM_BITS] ? '1 : bkg_add[SUM_BITS-1:0];
          state_d = BK_EVAL;
        end
      end
      BK_EVAL: begin
        if (sig_q == '0) begin
          state_d = BK_LAST;
        end else if (!found_q) begin
          best_s_d   = sig_q;
          best_t_d   = tot;
          best_pos_d = edge_q;
          found_d    = 1'b1;
          state_d    = BK_LAST;
        end else begin
          cmd0.start = 1'b1;
          cmd1.start = 1'b1;
          state_d    = BK_SQ;
        end
      end
      BK_SQ: begin
        cmd0.a = p0[SQ_BITS-1:0];
        cmd0.b = best_t_q;
        cmd1.a = p1[SQ_BITS-1:0];
        cmd1.b = tot;
        if (done0 && done1) begin
          cmd0.start = 1'b1;
          cmd1.start = 1'b1;
          state_d    = BK_PROD;
        end
      end
      BK_PROD: begin
        // s^2 * best_total against best_s^2 * total, strict
        if (done0 && done1) begin
          if (p0 > p1) begin
            best_s_d   = sig_q;
            best_t_d   = tot;
            best_pos_d = edge_q;
            found_d    = 1'b1;
          end
          state_d = BK_LAST;
        end
      end
      BK_LAST: begin
        cmd0.a = SQ_BITS'(best_s_q);
        cmd0.b = TOT_BITS'(best_s_q);
        if (!last_q) begin
          state_d = BK_IDLE;
        end else if (!found_q) begin
          state_d = BK_EMIT;
        end else begin
          cmd0.start = 1'b1;
          state_d    = BK_FSQ;
        end
      end
      BK_FSQ: begin
        if (done0) begin
          fig_start = 1'b1;
          state_d   = BK_FIG;
        end
      end
      BK_FIG: begin
        if (fig_done) state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load   = 1'b1;
          sig_d      = '0;
          bkg_d      = '0;
          best_s_d   = '0;
          best_t_d   = '0;
          best_pos_d = NONE_EDGE;
          found_d    = 1'b0;
          state_d    = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      edge_q <= q_item_i.bin_low_edge;
      last_q <= q_item_i.last_bin;
    end
    if (fig_done) fig_q <= fig;
    if (out_load) begin
      out_q.best_edge   <= found_q ? best_pos_q : NONE_EDGE;
      out_q.best_figure <= found_q ? fig_q : 32'd0;
      out_q.cut_found   <= found_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      sig_q       <= '0;
      bkg_q       <= '0;
      best_s_q    <= '0;
      best_t_q    <= '0;
      best_pos_q  <= NONE_EDGE;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      sig_q      <= sig_d;
      bkg_q      <= bkg_d;
      best_s_q   <= best_s_d;
      best_t_q   <= best_t_d;
      best_pos_q <= best_pos_d;
      found_q    <= found_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* src/cumulative_significance_cut_scan_core.sv */
// cut scan over histogram bins fed from the overflow bin down to the underflow
// bin; one result word follows the bin flagged last_bin. a two-entry queue
// takes bins while the back end works. a bin before the first score or with
// zero signal sum skips the multiplies; a scoring bin runs the two
// 8-bit-per-cycle multiply lanes that form s^2*best_total and
// best_s^2*total exactly. the last bin of a scan with a cut then forms the figure
// (square, 64-step restoring division, 32-step root) before the result is
// registered on the output side.
module cumulative_significance_cut_scan_core import csc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic     q_valid, q_pop;
  in_item_t q_item;

  csc_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_item_i,
    .q_valid_o(q_valid),
    .q_pop_i  (q_pop),
    .q_item_o (q_item)
  );

  csc_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid),
    .q_pop_o  (q_pop),
    .q_item_i (q_item),
    .out_valid_o,
    .out_ready_i,
    .out_item_o
  );

endmodule

/* tb/cumulative_significance_cut_scan_core_checker.sv */
`timescale 1ns / 100ps
module cumulative_significance_cut_scan_core_checker import csc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam logic [47:0] SUM_MAX = {48{1'b1}};

  logic [47:0]        sig_acc;
  logic [47:0]        bkg_acc;
  logic [47:0]        top_sig;
  logic [48:0]        top_tot;
  logic signed [31:0] top_edge;
  logic               have_top;
  out_item_t          cut_results_q[$];

  function automatic logic [47:0] sat_sum(logic [47:0] acc, logic [31:0] w);
    logic [48:0] r;
    r = {1'b0, acc} + {17'b0, w};
    return r[48] ? SUM_MAX : r[47:0];
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] x);
    logic [63:0] r;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      logic [63:0] c;
      c = r | (64'd1 << i);
      if ({64'b0, c} * {64'b0, c} <= {64'b0, x}) r = c;
    end
    return r;
  endfunction

  // floor(sqrt(s*s*2^24 / t)), saturated to 32 bits
  function automatic logic [31:0] merit(logic [47:0] s, logic [48:0] t);
    logic [191:0] sq, num;
    logic [63:0]  root;
    if (s == 0 || t == 0) return 32'd0;
    sq = {144'b0, s} * {144'b0, s};
    if (sq >= ({143'b0, t} << 40)) return 32'hFFFF_FFFF;
    num = sq << 24;
    root = int_root(64'(num / {143'b0, t}));
    return root[31:0];
  endfunction

  task automatic score_bin(in_item_t w);
    logic [48:0]  tot;
    logic [191:0] lhs, rhs;
    out_item_t    r;
    sig_acc = sat_sum(sig_acc, w.signal_weight);
    bkg_acc = sat_sum(bkg_acc, w.background_weight);
    tot = {1'b0, sig_acc} + {1'b0, bkg_acc};
    if (sig_acc != 0) begin
      lhs = {144'b0, sig_acc} * {144'b0, sig_acc} * {143'b0, top_tot};
      rhs = {144'b0, top_sig} * {144'b0, top_sig} * {143'b0, tot};
      if (!have_top || lhs > rhs) begin
        top_sig  = sig_acc;
        top_tot  = tot;
        top_edge = w.bin_low_edge;
        have_top = 1'b1;
      end
    end
    if (w.last_bin) begin
      r.best_edge   = have_top ? top_edge : NONE_EDGE;
      r.best_figure = have_top ? merit(top_sig, top_tot) : 32'd0;
      r.cut_found   = have_top;
      cut_results_q.push_back(r);
      sig_acc = 0; bkg_acc = 0; top_sig = 0; top_tot = 0;
      top_edge = NONE_EDGE; have_top = 1'b0;
    end
  endtask

  assign pending_o = cut_results_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_acc = 0; bkg_acc = 0; top_sig = 0; top_tot = 0;
      top_edge = NONE_EDGE; have_top = 1'b0;
      cut_results_q.delete();
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) score_bin(in_item_i);
      if (out_valid_i && out_ready_i) begin
        if (cut_results_q.size() == 0) begin
          $error("unexpected result word %p", out_item_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          out_item_t e;
          int bad;
          e = cut_results_q.pop_front();
          bad = 0;
          if (out_item_i.best_edge !== e.best_edge) begin
            $error("best_edge expected %0d actual %0d", e.best_edge, out_item_i.best_edge);
            bad++;
          end
          if (out_item_i.best_figure !== e.best_figure) begin
            $error("best_figure expected %0d actual %0d", e.best_figure,
                   out_item_i.best_figure);
            bad++;
          end
          if (out_item_i.cut_found !== e.cut_found) begin
            $error("cut_found expected %0d actual %0d", e.cut_found, out_item_i.cut_found);
            bad++;
          end
          if (bad != 0) fail_count_o <= fail_count_o + 1;
        end
      end
    end
  end

endmodule

/* tb/cumulative_significance_cut_scan_core_tb.sv */
`timescale 1ns / 100ps
module cumulative_significance_cut_scan_core_tb;
  import csc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  int        send_idle_pct;
  int        recv_idle_pct;
  bit        hold_recv;
  int        quiet_cycles;

  cumulative_significance_cut_scan_core uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_item_o(out_item)
  );

  cumulative_significance_cut_scan_core_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_item_i(out_item),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_recv) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // valid stays up between back-to-back words; idle cycles drop it
  task automatic send_word(logic [31:0] sw, logic [31:0] bw, logic [31:0] e, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{sw, bw, e, lst};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(255);
      3: return $urandom_range(65535);
      default: return $urandom;
    endcase
  endfunction

  // one histogram scan of n bins with random content
  task automatic send_scan(int n);
    for (int i = 0; i < n; i++) begin
      logic [31:0] sw, bw;
      sw = rand_weight();
      bw = rand_weight();
      if ($urandom_range(3) == 0) sw = 0;
      send_word(sw, bw, $urandom, i == n - 1);
    end
  endtask

  initial begin
    int sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    hold_recv = 1'b0;
    quiet_cycles = 0;
    send_idle_pct = 7;
    recv_idle_pct = 79;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty scan, zero signal, ties, extremes of edge
    send_word(0, 0, 32'h8000_0000, 1'b1);
    send_word(0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_word(32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 1'b1);
    send_word(32'h100, 0, 32'h0001_0000, 1'b0);
    send_word(0, 0, 32'h0002_0000, 1'b1);
    send_word(32'h100, 32'h300, 32'h0003_0000, 1'b0);
    send_word(32'h100, 32'h100, 32'h0004_0000, 1'b1);
    for (int i = 0; i < 8; i++)
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000 + i, i == 7);
    send_word(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 0, 32'h5555_AAAA, 1'b0);
    send_word(32'hAAAA_5555, 32'h5555_AAAA, 32'hAAAA_5555, 1'b1);

    // pressure: receiver holds off while bins keep coming
    fork
      begin
        hold_recv = 1'b1;
        repeat (1500) @(posedge clk);
        hold_recv = 1'b0;
      end
      begin
        for (int k = 0; k < 6; k++) send_scan(3);
        in_valid <= 1'b0;
      end
    join

    sent = 0;
    while (sent < 1400) begin
      int n;
      if (sent >= 470 && send_idle_pct == 7) begin
        send_idle_pct = 79; recv_idle_pct = 7;
      end else if (sent >= 940 && send_idle_pct == 79) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      send_scan(n);
      sent += n;
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

/* cumulative_significance_cut_scan_core.f */
src/csc_pkg.sv
src/csc_front.sv
src/csc_mul.sv
src/csc_figure.sv
src/csc_back.sv
src/cumulative_significance_cut_scan_core.sv
tb/cumulative_significance_cut_scan_core_checker.sv
tb/cumulative_significance_cut_scan_core_tb.sv
